// ===== sv/fcce_pkg.sv =====
// ----------------------------------------------------------------------------
// fcce_pkg: shared definitions for the cluster chain engine
// Operation, status and register codes, the controller command and status
// bundles, and helpers for entry widening.
// ----------------------------------------------------------------------------
package fcce_pkg;

	// Operation codes.
	localparam logic [2:0] OP_SET   = 3'd0;
	localparam logic [2:0] OP_GET   = 3'd1;
	localparam logic [2:0] OP_SCAN  = 3'd2;
	localparam logic [2:0] OP_CHECK = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;
	localparam logic [2:0] OP_INIT  = 3'd5;

	// Result status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_PROT    = 3'd2;
	localparam logic [2:0] ST_CROSS   = 3'd3;
	localparam logic [2:0] ST_BADCONT = 3'd4;

	// Entry formats.
	localparam logic [1:0] FW_12 = 2'd0;
	localparam logic [1:0] FW_16 = 2'd1;

	// Configuration register indexes.
	localparam logic [1:0] REG_FAT_WIDTH     = 2'd0;
	localparam logic [1:0] REG_CLUSTER_COUNT = 2'd1;
	localparam logic [1:0] REG_WRITE_PROTECT = 2'd2;
	localparam logic [1:0] REG_AUTO_TRUNCATE = 2'd3;

	// Write value selection.
	localparam logic [1:0] WS_VALUE = 2'd0;
	localparam logic [1:0] WS_EOF   = 2'd1;
	localparam logic [1:0] WS_ZERO  = 2'd2;

	localparam logic [31:0] CL_BAD  = 32'hffff_fff7;
	localparam logic [31:0] CL_EOFS = 32'hffff_fff8;
	localparam logic [31:0] CL_EOF  = 32'hffff_ffff;
	localparam logic [12:0] CNT_MAX = 13'd8191;
	localparam logic [7:0]  NIB_HI  = 8'hf0;
	localparam logic [7:0]  NIB_LO  = 8'h0f;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       rd_issue;
		logic       rd_cap;
		logic       k_clr;
		logic       wr_byte;
		logic [1:0] wsel;
		logic       st_we;
		logic [2:0] st_val;
		logic       nv_ent;
		logic       nv_wv;
		logic       nv_eof;
		logic       len_inc;
		logic       cur_ent;
		logic       cur_nxq;
		logic       nx_save;
		logic       head_clr_cl;
		logic       head_clr_ent;
		logic       cnt_free;
		logic       cnt_bad;
		logic       used_rd_ent;
		logic       used_set_ent;
		logic       used_clr_cur;
		logic       mod_set;
		logic       flag_rd;
		logic       sweep;
	} fcce_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] op;
		logic       wp;
		logic       at;
		logic       cur_valid;
		logic       len_lt_cc;
		logic       byte_last;
		logic       sweep_last;
		logic       ent_zero;
		logic       ent_bad;
		logic       ent_link;
		logic       ent_lt2;
		logic       ent_ge_cc;
		logic       ent_eofs;
		logic       ent_lt_cc;
		logic       used_bit;
	} fcce_stat_t;

	// Mask of the bits an entry holds in the given format.
	function automatic logic [31:0] entry_mask(input logic [1:0] fw);
		logic [31:0] m;
		case (fw)
			FW_12:   m = 32'h0000_0fff;
			FW_16:   m = 32'h0000_ffff;
			default: m = 32'h0fff_ffff;
		endcase
		return m;
	endfunction

	// Mask a raw value and widen reserved values with ones.
	function automatic logic [31:0] widen(input logic [1:0] fw, input logic [31:0] v);
		logic [31:0] m;
		logic [31:0] t;
		m = entry_mask(fw);
		t = v & m;
		if (t >= (CL_BAD & m)) begin
			t = t | ~m;
		end
		return t;
	endfunction

endpackage

// ===== sv/fcce_controller.sv =====
// ----------------------------------------------------------------------------
// fcce_controller: operation sequencer
// Steps each operation through entry reads, entry writes, bitmap accesses
// and chain walking, and raises the result strobe.
// ----------------------------------------------------------------------------
module fcce_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  fcce_pkg::fcce_stat_t stat,
	output fcce_pkg::fcce_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import fcce_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SWR  = 4'd1;
	localparam logic [3:0] S_SWO  = 4'd2;
	localparam logic [3:0] S_DISP = 4'd3;
	localparam logic [3:0] S_RDA  = 4'd4;
	localparam logic [3:0] S_RDD  = 4'd5;
	localparam logic [3:0] S_DEC  = 4'd6;
	localparam logic [3:0] S_WRB  = 4'd7;
	localparam logic [3:0] S_UDEC = 4'd8;
	localparam logic [3:0] S_NEXT = 4'd9;
	localparam logic [3:0] S_FLAG = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       trunc;

	assign trunc = stat.at && !stat.wp;
	assign busy  = (state_q != S_IDLE);
	assign done  = (state_q == S_DONE);

	// State register; reset starts with the bitmap clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_SWR, S_SWO: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = (state_q == S_SWR) ? S_IDLE : S_FLAG;
				end
			end
			S_DISP: begin
				state_d = S_FLAG;
				case (stat.op)
					OP_SET, OP_CLEAR: begin
						if (stat.wp) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_PROT;
						end else if (!stat.cur_valid) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_INVALID;
						end else begin
							state_d = S_RDA;
						end
					end
					OP_GET, OP_SCAN, OP_CHECK: begin
						if (!stat.cur_valid) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_INVALID;
							cmd.nv_eof = (stat.op == OP_GET);
						end else begin
							state_d = S_RDA;
						end
					end
					OP_INIT: begin
						state_d = S_SWO;
					end
					default: begin
						state_d = S_FLAG;
					end
				endcase
			end
			S_RDA: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_RDD;
			end
			S_RDD: begin
				cmd.rd_cap = 1'b1;
				if (stat.byte_last) begin
					cmd.k_clr = 1'b1;
					state_d   = S_DEC;
				end else begin
					state_d = S_RDA;
				end
			end
			S_DEC: begin
				state_d = S_FLAG;
				case (stat.op)
					OP_SET: begin
						cmd.wsel  = WS_VALUE;
						cmd.nv_wv = 1'b1;
						state_d   = S_WRB;
					end
					OP_GET: begin
						cmd.nv_ent = 1'b1;
					end
					OP_SCAN: begin
						cmd.nv_ent = 1'b1;
						if (stat.ent_zero) begin
							cmd.head_clr_cl = 1'b1;
							cmd.cnt_free    = 1'b1;
						end else if (stat.ent_bad) begin
							cmd.head_clr_cl = 1'b1;
							cmd.cnt_bad     = 1'b1;
						end else if (stat.ent_lt2 || (stat.ent_ge_cc && !stat.ent_eofs)) begin
							cmd.st_we  = 1'b1;
							cmd.st_val = ST_BADCONT;
							if (trunc) begin
								cmd.mod_set = 1'b1;
								cmd.wsel    = WS_EOF;
								state_d     = S_WRB;
							end
						end else if (stat.ent_lt_cc) begin
							cmd.head_clr_ent = 1'b1;
						end
					end
					OP_CHECK: begin
						if (stat.ent_link) begin
							cmd.used_rd_ent = 1'b1;
							state_d         = S_UDEC;
						end else begin
							cmd.nv_ent = 1'b1;
							if (stat.ent_eofs) begin
								cmd.len_inc = 1'b1;
							end else begin
								cmd.st_we  = 1'b1;
								cmd.st_val = ST_BADCONT;
								if (trunc) begin
									cmd.mod_set = 1'b1;
									cmd.wsel    = WS_EOF;
									state_d     = S_WRB;
								end
							end
						end
					end
					default: begin
						// Clear chain: keep the link, then free this entry.
						cmd.nx_save = 1'b1;
						cmd.wsel    = WS_ZERO;
						state_d     = S_WRB;
					end
				endcase
			end
			S_UDEC: begin
				if (stat.used_bit) begin
					cmd.st_we  = 1'b1;
					cmd.st_val = ST_CROSS;
					cmd.nv_ent = 1'b1;
					state_d    = S_FLAG;
					if (trunc) begin
						cmd.mod_set = 1'b1;
						cmd.wsel    = WS_EOF;
						state_d     = S_WRB;
					end
				end else begin
					cmd.len_inc      = 1'b1;
					cmd.used_set_ent = 1'b1;
					cmd.cur_ent      = 1'b1;
					state_d          = S_RDA;
				end
			end
			S_WRB: begin
				cmd.wr_byte = 1'b1;
				if (stat.op == OP_CLEAR) begin
					cmd.wsel = WS_ZERO;
				end else if (stat.op == OP_SET) begin
					cmd.wsel = WS_VALUE;
				end else begin
					cmd.wsel = WS_EOF;
				end
				if (stat.byte_last) begin
					cmd.k_clr = 1'b1;
					if (stat.op == OP_CLEAR) begin
						cmd.used_clr_cur = 1'b1;
						cmd.len_inc      = 1'b1;
						cmd.cur_nxq      = 1'b1;
						state_d          = S_NEXT;
					end else begin
						state_d = S_FLAG;
					end
				end
			end
			S_NEXT: begin
				state_d = (stat.cur_valid && stat.len_lt_cc) ? S_RDA : S_FLAG;
			end
			S_FLAG: begin
				cmd.flag_rd = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/fcce_datapath.sv =====
// ----------------------------------------------------------------------------
// fcce_datapath: table memory, bitmaps, counters and result registers
// Executes byte-wise entry reads and writes, bitmap updates and the
// clearing sweep on command from the controller.
// ----------------------------------------------------------------------------
module fcce_datapath #(
	parameter int MAX_CLUSTERS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [2:0]           op,
	input  logic [27:0]          cluster,
	input  logic [31:0]          write_value,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [12:0]          cfg_wdata,
	input  fcce_pkg::fcce_cmd_t  cmd,
	output fcce_pkg::fcce_stat_t stat,
	output logic [2:0]           status,
	output logic [31:0]          next_value,
	output logic [12:0]          chain_length,
	output logic                 head_flag,
	output logic                 used_flag,
	output logic [12:0]          free_total,
	output logic [12:0]          bad_total,
	output logic                 table_modified
);
	import fcce_pkg::*;

	localparam int MW = $clog2(MAX_CLUSTERS);
	localparam int AW = MW + 2;
	localparam int TB = 4 * MAX_CLUSTERS;
	localparam logic [31:0] MAXC = 32'(MAX_CLUSTERS);
	localparam logic [MW-1:0] LAST_IDX = MW'(MAX_CLUSTERS - 1);

	logic [1:0]    fat_q;
	logic [12:0]   ccount_q;
	logic          wp_q;
	logic          at_q;
	logic [2:0]    op_q;
	logic [27:0]   cl_q;
	logic [31:0]   wv_q;
	logic [31:0]   cur_q;
	logic [31:0]   nx_q;
	logic [31:0]   raw_q;
	logic [1:0]    k_q;
	logic [2:0]    status_q;
	logic [31:0]   nv_q;
	logic [12:0]   len_q;
	logic          mod_q;
	logic [12:0]   free_q;
	logic [12:0]   bad_q;
	logic [MW-1:0] sw_q;
	logic [7:0]    rd_q;
	logic          hd_q;
	logic          ud_q;

	logic [31:0]   cc;
	logic [31:0]   pre;
	logic [31:0]   ent;
	logic [31:0]   wval;
	logic [31:0]   nw;
	logic [7:0]    wbyte;
	logic [AW-1:0] ca;
	logic [AW-1:0] base;
	logic [AW-1:0] addr;
	logic          cl_lt_cc;

	logic [7:0] tbl  [TB];
	logic       hmap [MAX_CLUSTERS];
	logic       umap [MAX_CLUSTERS];

	// Effective cluster count.
	assign cc       = (32'(ccount_q) > MAXC) ? MAXC : 32'(ccount_q);
	assign cl_lt_cc = (32'(cl_q) < cc);

	// Entry of the current cluster from the gathered bytes.
	always_comb begin
		case (fat_q)
			FW_12:   pre = cur_q[0] ? {20'b0, raw_q[15:4]} : {16'b0, raw_q[15:0]};
			FW_16:   pre = {16'b0, raw_q[15:0]};
			default: pre = raw_q;
		endcase
		ent = widen(fat_q, pre);
	end

	// Byte address of byte k of the current entry.
	assign ca = AW'(cur_q[MW-1:0]);
	always_comb begin
		case (fat_q)
			FW_12:   base = ca + (ca >> 1);
			FW_16:   base = ca << 1;
			default: base = ca << 2;
		endcase
		addr = base + AW'(k_q);
	end

	// New entry bytes; twelve-bit entries keep the neighbour's nibble.
	always_comb begin
		case (cmd.wsel)
			WS_VALUE: wval = wv_q;
			WS_EOF:   wval = CL_EOF;
			default:  wval = 32'd0;
		endcase
		case (fat_q)
			FW_12: begin
				if (cur_q[0]) begin
					nw = {16'b0, (16'(wval[11:0]) << 4) | {8'h00, raw_q[7:0] & NIB_LO}};
				end else begin
					nw = {16'b0, 16'(wval[11:0]) | {raw_q[15:8] & NIB_HI, 8'h00}};
				end
			end
			FW_16:   nw = {16'b0, wval[15:0]};
			default: nw = {4'b0, wval[27:0]};
		endcase
		wbyte = nw[8*k_q +: 8];
	end

	// Table byte memory.
	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			tbl[addr] <= wbyte;
		end
		if (cmd.rd_issue) begin
			rd_q <= tbl[addr];
		end
	end

	// Head bitmap.
	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			hmap[sw_q] <= 1'b1;
		end else if (cmd.head_clr_cl) begin
			hmap[cl_q[MW-1:0]] <= 1'b0;
		end else if (cmd.head_clr_ent) begin
			hmap[ent[MW-1:0]] <= 1'b0;
		end
		if (cmd.flag_rd) begin
			hd_q <= hmap[cl_q[MW-1:0]];
		end
	end

	// Used bitmap.
	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			umap[sw_q] <= 1'b0;
		end else if (cmd.used_set_ent) begin
			umap[ent[MW-1:0]] <= 1'b1;
		end else if (cmd.used_clr_cur) begin
			umap[cur_q[MW-1:0]] <= 1'b0;
		end
		if (cmd.used_rd_ent) begin
			ud_q <= umap[ent[MW-1:0]];
		end else if (cmd.flag_rd) begin
			ud_q <= umap[cl_q[MW-1:0]];
		end
	end

	// Configuration, byte counter, sweep index and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fat_q    <= 2'd2;
			ccount_q <= 13'd4096;
			wp_q     <= 1'b0;
			at_q     <= 1'b0;
			k_q      <= 2'd0;
			sw_q     <= '0;
			free_q   <= 13'd0;
			bad_q    <= 13'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_FAT_WIDTH:     fat_q    <= cfg_wdata[1:0];
					REG_CLUSTER_COUNT: ccount_q <= cfg_wdata;
					REG_WRITE_PROTECT: wp_q     <= cfg_wdata[0];
					REG_AUTO_TRUNCATE: at_q     <= cfg_wdata[0];
					default:           at_q     <= at_q;
				endcase
			end
			if (cmd.k_clr) begin
				k_q <= 2'd0;
			end else if (cmd.rd_cap || cmd.wr_byte) begin
				k_q <= k_q + 2'd1;
			end
			if (cmd.sweep) begin
				sw_q <= (sw_q == LAST_IDX) ? '0 : sw_q + 1'b1;
			end
			if (cmd.sweep) begin
				free_q <= 13'd0;
				bad_q  <= 13'd0;
			end else begin
				if (cmd.cnt_free && free_q != CNT_MAX) begin
					free_q <= free_q + 13'd1;
				end
				if (cmd.cnt_bad && bad_q != CNT_MAX) begin
					bad_q <= bad_q + 13'd1;
				end
			end
		end
	end

	// Item and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			cl_q     <= cluster;
			wv_q     <= write_value;
			status_q <= ST_OK;
			nv_q     <= 32'd0;
			len_q    <= 13'd0;
			mod_q    <= 1'b0;
		end else begin
			if (cmd.st_we) begin
				status_q <= cmd.st_val;
			end
			if (cmd.nv_ent) begin
				nv_q <= ent;
			end else if (cmd.nv_wv) begin
				nv_q <= widen(fat_q, wv_q);
			end else if (cmd.nv_eof) begin
				nv_q <= CL_EOF;
			end
			if (cmd.len_inc) begin
				len_q <= len_q + 13'd1;
			end
			if (cmd.mod_set) begin
				mod_q <= 1'b1;
			end
		end
		if (cmd.load) begin
			cur_q <= 32'(cluster);
		end else if (cmd.cur_ent) begin
			cur_q <= ent;
		end else if (cmd.cur_nxq) begin
			cur_q <= nx_q;
		end
		if (cmd.nx_save) begin
			nx_q <= ent;
		end
		if (cmd.rd_cap) begin
			raw_q[8*k_q +: 8] <= rd_q;
		end
	end

	// Status towards the controller.
	always_comb begin
		stat.op         = op_q;
		stat.wp         = wp_q;
		stat.at         = at_q;
		stat.cur_valid  = (cur_q >= 32'd2) && (cur_q < cc);
		stat.len_lt_cc  = (32'(len_q) < cc);
		stat.byte_last  = (k_q == (((fat_q == FW_12) || (fat_q == FW_16)) ? 2'd1 : 2'd3));
		stat.sweep_last = (sw_q == LAST_IDX);
		stat.ent_zero   = (ent == 32'd0);
		stat.ent_bad    = (ent == CL_BAD);
		stat.ent_lt2    = (ent < 32'd2);
		stat.ent_ge_cc  = (ent >= cc);
		stat.ent_lt_cc  = (ent < cc);
		stat.ent_link   = (ent >= 32'd2) && (ent < cc);
		stat.ent_eofs   = (ent >= CL_EOFS);
		stat.used_bit   = ud_q;
	end

	assign status         = status_q;
	assign next_value     = nv_q;
	assign chain_length   = len_q;
	assign head_flag      = hd_q & cl_lt_cc;
	assign used_flag      = ud_q & cl_lt_cc;
	assign free_total     = free_q;
	assign bad_total      = bad_q;
	assign table_modified = mod_q;

endmodule

// ===== sv/fat_cluster_chain_engine.sv =====
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine: FAT allocation table engine
// Holds a packed 12/16/32-bit allocation table in byte memory with head and
// used bitmaps; sets, reads and scans entries and checks or clears chains.
//
//  Channel  | Signals                                   | Beat taken when
//  ---------+-------------------------------------------+------------------
//  command  | start, busy, op, cluster, write_value     | start & !busy
//  result   | done, status, next_value, chain_length,   | done (one cycle)
//           | head_flag, used_flag, free_total,         |
//           | bad_total, table_modified                 |
//  config   | cfg_we, cfg_idx, cfg_wdata                | cfg_we
//
// The table memory has one byte port, so entries are read and written byte
// by byte (two bytes for 12/16-bit formats, four for 32-bit): each byte read
// passes an address state and a capture state, each byte write one write
// state. A written entry is read first, then written back; check repeats the
// read and clear the read and write per chain link. Init maps sweeps every
// entry of both bitmaps. After reset the same sweep runs with busy high.
// The receiver cannot stall: a result is shown for the single done cycle.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine #(
	parameter int MAX_CLUSTERS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [27:0] cluster,
	input  logic [31:0] write_value,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [12:0] cfg_wdata,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] next_value,
	output logic [12:0] chain_length,
	output logic        head_flag,
	output logic        used_flag,
	output logic [12:0] free_total,
	output logic [12:0] bad_total,
	output logic        table_modified
);
	import fcce_pkg::*;

	fcce_cmd_t  cmd;
	fcce_stat_t stat;

	// Sequencer.
	fcce_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Storage and arithmetic.
	fcce_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.cluster        (cluster),
		.write_value    (write_value),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.cmd            (cmd),
		.stat           (stat),
		.status         (status),
		.next_value     (next_value),
		.chain_length   (chain_length),
		.head_flag      (head_flag),
		.used_flag      (used_flag),
		.free_total     (free_total),
		.bad_total      (bad_total),
		.table_modified (table_modified)
	);

endmodule

// ===== sv/fcce_checker.sv =====
// ----------------------------------------------------------------------------
// fcce_assertions: port-level checks for the cluster chain engine
// Watches the command and result beats and the result contents.
// ----------------------------------------------------------------------------
module fcce_assertions (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [12:0] chain_length,
	input logic        table_modified
);
	import fcce_pkg::*;

	// An accepted command keeps the engine busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("engine not busy after command beat");

	// The engine is free again straight after a result beat.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("engine still busy after result beat");

	// Status codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= ST_BADCONT))
		else $error("undefined status code");

	// A rejected cluster never counts or truncates.
	a_invalid_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_INVALID) |-> (chain_length == 13'd0 && !table_modified))
		else $error("invalid cluster result with side effects");

	// A truncation only follows a crossed chain or a bad continuation.
	a_trunc_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_modified) |-> (status == ST_CROSS || status == ST_BADCONT))
		else $error("truncation without a chain fault");

endmodule

bind fat_cluster_chain_engine fcce_assertions u_fcce_assertions (.*);

// ===== bench/fcce_checker.sv =====
// ----------------------------------------------------------------------------
// fcce_checker: result predictor and scoreboard for the cluster chain engine
// Mirrors the allocation table, both bitmaps, the counters and the registers.
// Each accepted command beat is turned into an expected result. Each done beat
// is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module fcce_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  op,
	input  logic [27:0] cluster,
	input  logic [31:0] write_value,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [12:0] cfg_wdata,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic [31:0] next_value,
	input  logic [12:0] chain_length,
	input  logic        head_flag,
	input  logic        used_flag,
	input  logic [12:0] free_total,
	input  logic [12:0] bad_total,
	input  logic        table_modified,
	output int          fail_count,
	output int          pending
);
	import fcce_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_CLUSTERS = 4096;
	localparam int TABLE_SIZE     = TABLE_CLUSTERS * 4;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] next_value;
		logic [12:0] chain_length;
		logic        head_flag;
		logic        used_flag;
		logic [12:0] free_total;
		logic [12:0] bad_total;
		logic        table_modified;
	} chain_result_t;

	// Mirror of the engine state and registers.
	logic [7:0]  fat_bytes [TABLE_SIZE];
	bit          head_bits [TABLE_CLUSTERS];
	bit          used_bits [TABLE_CLUSTERS];
	logic [12:0] free_seen;
	logic [12:0] bad_seen;
	logic [1:0]  width_sel;
	logic [12:0] count_reg;
	bit          protect_on;
	bit          truncate_on;

	chain_result_t results_due [$];

	function automatic int unsigned clusters_in_use();
		return (count_reg > TABLE_CLUSTERS) ? TABLE_CLUSTERS : count_reg;
	endfunction

	function automatic bit in_range(int unsigned c);
		return c >= 2 && c < clusters_in_use();
	endfunction

	function automatic logic [31:0] byte_at(int unsigned a);
		return (a < TABLE_SIZE) ? {24'd0, fat_bytes[a]} : 32'd0;
	endfunction

	function automatic void byte_put(int unsigned a, logic [31:0] v);
		if (a < TABLE_SIZE) begin
			fat_bytes[a] = v[7:0];
		end
	endfunction

	// Read one entry and extend reserved values with ones.
	function automatic logic [31:0] link_of(int unsigned c);
		int unsigned a;
		logic [31:0] v;
		logic [31:0] m;
		case (width_sel)
			FW_12: begin
				a = c + (c >> 1);
				v = byte_at(a) | (byte_at(a + 1) << 8);
				if (c[0]) begin
					v = v >> 4;
				end
				m = 32'h0000_0fff;
			end
			FW_16: begin
				a = c * 2;
				v = byte_at(a) | (byte_at(a + 1) << 8);
				m = 32'h0000_ffff;
			end
			default: begin
				a = c * 4;
				v = byte_at(a) | (byte_at(a + 1) << 8) | (byte_at(a + 2) << 16)
					| (byte_at(a + 3) << 24);
				m = 32'h0fff_ffff;
			end
		endcase
		v = v & m;
		if (v >= (CL_BAD & m)) begin
			v = v | ~m;
		end
		return v;
	endfunction

	// Store one entry; twelve-bit entries share a byte with their neighbour.
	function automatic void link_put(int unsigned c, logic [31:0] v);
		int unsigned a;
		case (width_sel)
			FW_12: begin
				a = c + (c >> 1);
				v = v & 32'h0000_0fff;
				if (!c[0]) begin
					v = v | ((byte_at(a + 1) & {24'd0, NIB_HI}) << 8);
				end else begin
					v = (v << 4) | (byte_at(a) & {24'd0, NIB_LO});
				end
				byte_put(a, v);
				byte_put(a + 1, v >> 8);
			end
			FW_16: begin
				a = c * 2;
				byte_put(a, v);
				byte_put(a + 1, v >> 8);
			end
			default: begin
				a = c * 4;
				v = v & 32'h0fff_ffff;
				byte_put(a, v);
				byte_put(a + 1, v >> 8);
				byte_put(a + 2, v >> 16);
				byte_put(a + 3, v >> 24);
			end
		endcase
	endfunction

	function automatic logic cut_link(int unsigned c);
		if (truncate_on && !protect_on) begin
			link_put(c, CL_EOF);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void clear_maps();
		foreach (head_bits[i]) begin
			head_bits[i] = 1'b1;
			used_bits[i] = 1'b0;
		end
		free_seen = '0;
		bad_seen  = '0;
	endfunction

	// Work out the result of one command and update the mirror.
	function automatic chain_result_t run_command(logic [2:0] code, int unsigned cl,
			logic [31:0] wv);
		chain_result_t r;
		int unsigned cc;
		int unsigned cur;
		int unsigned steps;
		logic [31:0] nx;
		cc = clusters_in_use();
		r = '0;
		nx = '0;
		case (code)
			OP_SET: begin
				if (protect_on) begin
					r.status = ST_PROT;
				end else if (!in_range(cl)) begin
					r.status = ST_INVALID;
				end else begin
					link_put(cl, wv);
					r.next_value = link_of(cl);
				end
			end
			OP_GET: begin
				if (!in_range(cl)) begin
					r.status = ST_INVALID;
					r.next_value = CL_EOF;
				end else begin
					r.next_value = link_of(cl);
				end
			end
			OP_SCAN: begin
				if (!in_range(cl)) begin
					r.status = ST_INVALID;
				end else begin
					nx = link_of(cl);
					r.next_value = nx;
					if (nx == 0) begin
						head_bits[cl] = 1'b0;
						if (free_seen < CNT_MAX) free_seen++;
					end else if (nx == CL_BAD) begin
						head_bits[cl] = 1'b0;
						if (bad_seen < CNT_MAX) bad_seen++;
					end else if (nx < 2 || (nx >= cc && nx < CL_EOFS)) begin
						r.status = ST_BADCONT;
						r.table_modified = cut_link(cl);
					end else if (nx < cc) begin
						head_bits[nx] = 1'b0;
					end
				end
			end
			OP_CHECK: begin
				if (!in_range(cl)) begin
					r.status = ST_INVALID;
				end else begin
					cur = cl;
					forever begin
						nx = link_of(cur);
						if (nx < 2 || nx >= cc) break;
						if (used_bits[nx]) begin
							r.status = ST_CROSS;
							break;
						end
						r.chain_length++;
						used_bits[nx] = 1'b1;
						cur = nx;
					end
					r.next_value = nx;
					if (r.status == ST_OK) begin
						if (nx >= CL_EOFS) r.chain_length++;
						else r.status = ST_BADCONT;
					end
					if (r.status != ST_OK) begin
						r.table_modified = cut_link(cur);
					end
				end
			end
			OP_CLEAR: begin
				if (protect_on) begin
					r.status = ST_PROT;
				end else if (!in_range(cl)) begin
					r.status = ST_INVALID;
				end else begin
					cur = cl;
					for (steps = 0; in_range(cur) && steps < cc; steps++) begin
						nx = link_of(cur);
						link_put(cur, 32'd0);
						used_bits[cur] = 1'b0;
						r.chain_length++;
						cur = nx;
					end
				end
			end
			OP_INIT: clear_maps();
			default: ;
		endcase
		r.head_flag  = (cl < cc) ? head_bits[cl] : 1'b0;
		r.used_flag  = (cl < cc) ? used_bits[cl] : 1'b0;
		r.free_total = free_seen;
		r.bad_total  = bad_seen;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Score result beats first, then registers, then the new command beat.
	always @(posedge clk or negedge arst_n) begin
		chain_result_t want;
		if (!arst_n) begin
			clear_maps();
			width_sel   = 2'd2;
			count_reg   = 13'd4096;
			protect_on  = 1'b0;
			truncate_on = 1'b0;
			results_due.delete();
			fail_count  = 0;
			pending     = 0;
		end else begin
			if (done) begin
				if (results_due.size() == 0) begin
					$display("%0t: result beat with nothing expected, status %h", $time, status);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					compare_field("status", 32'(want.status), 32'(status));
					compare_field("next_value", want.next_value, next_value);
					compare_field("chain_length", 32'(want.chain_length),
						32'(chain_length));
					compare_field("head_flag", 32'(want.head_flag), 32'(head_flag));
					compare_field("used_flag", 32'(want.used_flag), 32'(used_flag));
					compare_field("free_total", 32'(want.free_total), 32'(free_total));
					compare_field("bad_total", 32'(want.bad_total), 32'(bad_total));
					compare_field("table_modified", 32'(want.table_modified),
						32'(table_modified));
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_FAT_WIDTH:     width_sel   = cfg_wdata[1:0];
					REG_CLUSTER_COUNT: count_reg   = cfg_wdata;
					REG_WRITE_PROTECT: protect_on  = cfg_wdata[0];
					REG_AUTO_TRUNCATE: truncate_on = cfg_wdata[0];
					default:           ;
				endcase
			end
			if (start && !busy) begin
				results_due.push_back(run_command(op, cluster, write_value));
			end
			pending = results_due.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the cluster chain engine
// Fills the low part of the table in every format, runs directed commands on
// the edge cases, then random phases of chain-building sequences and noise
// under many register settings, with random gaps between command beats.
// ----------------------------------------------------------------------------
module tb_top;
	import fcce_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam logic [1:0] FW_32      = 2'd2;
	localparam logic [1:0] FW_ALT32   = 2'd3;
	localparam int STALL_LIMIT   = 250000;
	localparam int PHASES        = 18;
	localparam int FILL_CLUSTERS = 512;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  op = '0;
	logic [27:0] cluster = '0;
	logic [31:0] write_value = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [12:0] cfg_wdata = '0;
	logic        busy, done, head_flag, used_flag, table_modified;
	logic [2:0]  status;
	logic [31:0] next_value;
	logic [12:0] chain_length, free_total, bad_total;
	int          fail_count, pending;

	int          sent_beats = 0;
	int          settings_run = 0;
	int          active_count = 4096;
	bit          gaps_on = 1'b1;
	int          quiet_cycles = 0;

	fat_cluster_chain_engine DUT (.*);
	fcce_checker checker_i (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// Watchdog: cycles without any beat or register write.
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One command beat, with an occasional gap ahead of it.
	task automatic send(logic [2:0] code, logic [27:0] cl, logic [31:0] wv);
		if (gaps_on && $urandom_range(99) < 30) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		op <= code;
		cluster <= cl;
		write_value <= wv;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		sent_beats++;
	endtask

	// Hold off until every result is back and the engine is idle.
	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(logic [1:0] fw, logic [12:0] cc, bit wp, bit at);
		cfg_we <= 1'b1;
		cfg_idx <= REG_FAT_WIDTH;
		cfg_wdata <= {11'd0, fw};
		@(posedge clk);
		cfg_idx <= REG_CLUSTER_COUNT;
		cfg_wdata <= cc;
		@(posedge clk);
		cfg_idx <= REG_WRITE_PROTECT;
		cfg_wdata <= {12'd0, wp};
		@(posedge clk);
		cfg_idx <= REG_AUTO_TRUNCATE;
		cfg_wdata <= {12'd0, at};
		@(posedge clk);
		cfg_we <= 1'b0;
		active_count = (cc > 4096) ? 4096 : cc;
		settings_run++;
	endtask

	function automatic logic [27:0] pick_cluster();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5) return 28'($urandom());
		return 28'($urandom_range(active_count + 1));
	endfunction

	function automatic logic [31:0] pick_link();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55) return $urandom_range(active_count > 2 ? active_count - 1 : 2, 2);
		if (r < 70) return CL_EOFS | $urandom_range(7);
		if (r < 75) return CL_BAD;
		if (r < 85) return 32'd0;
		if (r < 88) return $urandom_range(1);
		return $urandom();
	endfunction

	function automatic logic [2:0] pick_op();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 35) return OP_SET;
		if (r < 47) return OP_GET;
		if (r < 65) return OP_SCAN;
		if (r < 82) return OP_CHECK;
		if (r < 92) return OP_CLEAR;
		if (r < 96) return OP_INIT;
		return $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
	endfunction

	// A linked chain with random members, then commands that walk it.
	task automatic chain_sequence();
		logic [27:0] head;
		logic [27:0] here;
		logic [27:0] there;
		int links;
		head = 28'($urandom_range(active_count > 2 ? active_count - 1 : 2, 2));
		here = head;
		links = $urandom_range(1, 6);
		repeat (links) begin
			there = 28'($urandom_range(active_count > 2 ? active_count - 1 : 2, 2));
			send(OP_SET, here, {4'd0, there});
			here = there;
		end
		send(OP_SET, here, ($urandom_range(9) == 0) ? pick_link() : CL_EOF);
		if ($urandom_range(1)) send(OP_SCAN, head, 0);
		send(OP_CHECK, head, 0);
		if ($urandom_range(3) == 0) send(OP_CLEAR, head, 0);
	endtask

	initial begin
		int quota;
		int phase_beats;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// Write every table byte a later read can touch.
		configure(FW_16, 13'd4096, 1'b0, 1'b0);
		send(OP_SET, 2, 32'd0);
		send(OP_SET, 3, 32'd0);
		settle();
		configure(FW_12, 13'd4096, 1'b0, 1'b0);
		send(OP_SET, 2, 32'd0);
		settle();
		configure(FW_32, 13'd4096, 1'b0, 1'b0);
		for (int c = 2; c < FILL_CLUSTERS; c++) send(OP_SET, 28'(c), pick_link());

		// Directed edge cases.
		send(OP_GET, 0, 0);
		send(OP_GET, 28'hfff_ffff, 0);
		send(OP_SET, 1, 32'hffff_ffff);
		send(OP_SET, 4095, 32'hffff_ffff);
		send(OP_GET, 4095, 0);
		send(OP_SET, 10, 32'd11);
		send(OP_SET, 11, 32'd12);
		send(OP_SET, 12, CL_EOF);
		send(OP_CHECK, 10, 0);
		send(OP_CHECK, 10, 0);
		send(OP_SET, 20, CL_BAD);
		send(OP_SCAN, 20, 0);
		send(OP_SET, 21, 32'd1);
		send(OP_SCAN, 21, 0);
		send(OP_SET, 22, 32'd0);
		send(OP_SCAN, 22, 0);
		send(OP_SCAN, 10, 0);
		send(OP_CLEAR, 10, 0);
		send(OP_INIT, 0, 0);
		send(OP_SPARE_A, 5, 0);
		send(OP_SPARE_B, 5, 0);
		settle();
		configure(FW_ALT32, 13'd8191, 1'b1, 1'b1);
		send(OP_SET, 30, 32'd31);
		send(OP_CLEAR, 30, 0);
		send(OP_SCAN, 21, 0);
		send(OP_GET, 4095, 0);
		send(OP_SCAN, 5000, 0);
		settle();

		// Random phases under changing register settings.
		for (int p = 0; p < PHASES; p++) begin
			logic [12:0] cc;
			case (p)
				0, 9:  cc = 13'd512;
				1:     cc = 13'd2;
				2:     cc = 13'd3;
				default: cc = $urandom_range(16, 96);
			endcase
			configure(2'(p % 4), cc, (p % 5) == 4, p[0]);
			gaps_on = !(p == 6 || p == 7);
			quota = 65;
			phase_beats = sent_beats + quota;
			while (sent_beats < phase_beats) begin
				if ($urandom_range(99) < 60) begin
					chain_sequence();
				end else begin
					send(pick_op(), pick_cluster(), pick_link());
				end
				if (p == 5 && sent_beats >= phase_beats - quota / 2 && sent_beats < phase_beats - quota / 2 + 3)
					settle();
			end
			settle();
		end

		$display("Run covered %0d command beats over %0d register settings,", sent_beats,
			settings_run);
		$display("spanning all entry formats, protection, truncation and chain walks.");
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
